### sv/mexp_pkg.sv
// Shared constants, types and the microcode program of the modular exponentiation unit.
// Used by the interfaces, the sequencer, the datapath and the top level; no dependencies.
`default_nettype none
package mexp_pkg;

    localparam int EXP_WIDTH    = 63;
    localparam int MOD_WIDTH    = 31;
    localparam int BASE_WIDTH   = 32;
    localparam int RESULT_WIDTH = MOD_WIDTH;

    localparam int EXP_IDX_W = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;
    localparam int MUL_W     = MOD_WIDTH + BASE_WIDTH;
    // Two quotient bits are retired per reduction step.
    localparam int RED_STEPS = (MUL_W + 1) / 2;
    localparam int PROD_W    = 2 * RED_STEPS;
    localparam int RCNT_W    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

    localparam logic [MOD_WIDTH-1:0] MOD_RESET = MOD_WIDTH'(64'd1000000007);

    localparam int PC_W = 4;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_SQUARE,
        MUL_BASE
    } mul_op_t;

    typedef enum logic [1:0] {
        T_HOLD,
        T_REM,
        T_ZERO
    } t_op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_EXP_ZERO,
        C_MOD_ZERO,
        C_RED_MORE,
        C_BIT_CLR,
        C_BIT_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic    in_ready;
        mul_op_t mul_op;
        logic    red_step;
        t_op_t   t_op;
        logic    exp_step;
        logic    out_load;
    } act_t;

    typedef struct packed {
        cond_t             cond;
        logic [PC_W-1:0]   target;
        act_t              act;
    } ucode_t;

    typedef struct packed {
        logic in_acc;
        logic exp_zero;
        logic mod_zero;
        logic red_more;
        logic bit_clr;
        logic bit_more;
        logic out_busy;
    } status_t;

    localparam logic [PC_W-1:0] PC_IDLE     = PC_W'(0);
    localparam logic [PC_W-1:0] PC_CHK_EXP  = PC_W'(1);
    localparam logic [PC_W-1:0] PC_CHK_MOD  = PC_W'(2);
    localparam logic [PC_W-1:0] PC_SQ       = PC_W'(3);
    localparam logic [PC_W-1:0] PC_SQ_RED   = PC_W'(4);
    localparam logic [PC_W-1:0] PC_SQ_WB    = PC_W'(5);
    localparam logic [PC_W-1:0] PC_ML       = PC_W'(6);
    localparam logic [PC_W-1:0] PC_ML_RED   = PC_W'(7);
    localparam logic [PC_W-1:0] PC_ML_WB    = PC_W'(8);
    localparam logic [PC_W-1:0] PC_NEXT_BIT = PC_W'(9);
    localparam logic [PC_W-1:0] PC_FINISH   = PC_W'(10);
    localparam logic [PC_W-1:0] PC_ZERO     = PC_W'(11);
    localparam logic [PC_W-1:0] PC_DONE     = PC_W'(15);

    function automatic ucode_t uc(
        input cond_t           cond,
        input logic [PC_W-1:0] target,
        input logic            in_ready,
        input mul_op_t         mul_op,
        input logic            red_step,
        input t_op_t           t_op,
        input logic            exp_step,
        input logic            out_load
    );
        ucode_t w;
        w.cond         = cond;
        w.target       = target;
        w.act.in_ready = in_ready;
        w.act.mul_op   = mul_op;
        w.act.red_step = red_step;
        w.act.t_op     = t_op;
        w.act.exp_step = exp_step;
        w.act.out_load = out_load;
        return w;
    endfunction

    // When the condition holds the sequencer jumps to the target, otherwise it steps on.
    // The done step is the last entry, so stepping on from it wraps to idle.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            PC_IDLE:     w = uc(C_NO_REQ,   PC_IDLE,   1'b1, MUL_NONE,   1'b0, T_HOLD, 1'b0, 1'b0);
            PC_CHK_EXP:  w = uc(C_EXP_ZERO, PC_DONE,   1'b0, MUL_NONE,   1'b0, T_HOLD, 1'b0, 1'b0);
            PC_CHK_MOD:  w = uc(C_MOD_ZERO, PC_ZERO,   1'b0, MUL_NONE,   1'b0, T_HOLD, 1'b0, 1'b0);
            PC_SQ:       w = uc(C_NEVER,    PC_IDLE,   1'b0, MUL_SQUARE, 1'b0, T_HOLD, 1'b0, 1'b0);
            PC_SQ_RED:   w = uc(C_RED_MORE, PC_SQ_RED, 1'b0, MUL_NONE,   1'b1, T_HOLD, 1'b0, 1'b0);
            PC_SQ_WB:    w = uc(C_BIT_CLR, PC_NEXT_BIT, 1'b0, MUL_NONE,  1'b0, T_REM,  1'b0, 1'b0);
            PC_ML:       w = uc(C_NEVER,    PC_IDLE,   1'b0, MUL_BASE,   1'b0, T_HOLD, 1'b0, 1'b0);
            PC_ML_RED:   w = uc(C_RED_MORE, PC_ML_RED, 1'b0, MUL_NONE,   1'b1, T_HOLD, 1'b0, 1'b0);
            PC_ML_WB:    w = uc(C_NEVER,    PC_IDLE,   1'b0, MUL_NONE,   1'b0, T_REM,  1'b0, 1'b0);
            PC_NEXT_BIT: w = uc(C_BIT_MORE, PC_SQ,     1'b0, MUL_NONE,   1'b0, T_HOLD, 1'b1, 1'b0);
            PC_FINISH:   w = uc(C_ALWAYS,   PC_DONE,   1'b0, MUL_NONE,   1'b0, T_HOLD, 1'b0, 1'b0);
            PC_ZERO:     w = uc(C_ALWAYS,   PC_DONE,   1'b0, MUL_NONE,   1'b0, T_ZERO, 1'b0, 1'b0);
            PC_DONE:     w = uc(C_OUT_BUSY, PC_DONE,   1'b0, MUL_NONE,   1'b0, T_HOLD, 1'b0, 1'b1);
            default:     w = uc(C_ALWAYS,   PC_IDLE,   1'b0, MUL_NONE,   1'b0, T_HOLD, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

### sv/mexp_ifs.sv
// Request, response and modulus write channels of the modular exponentiation unit.
// Depends on mexp_pkg for the field widths.
`default_nettype none
interface mexp_req_if
    import mexp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [BASE_WIDTH-1:0] base;
    logic [EXP_WIDTH-1:0]  exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_rsp_if
    import mexp_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [RESULT_WIDTH-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

interface mexp_cfg_if
    import mexp_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [MOD_WIDTH-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink   (input valid, input modulus, output ready);
endinterface
`default_nettype wire

### sv/mexp_seq.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on mexp_pkg for the program and the control and status structs.
`default_nettype none
module mexp_seq
    import mexp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t status,
    output act_t         act
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          word;
    logic            hit;

    always_comb
    begin
        word = ucode_rom(pc_reg);
        act  = word.act;
    end

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:    hit = 1'b0;
            C_ALWAYS:   hit = 1'b1;
            C_NO_REQ:   hit = !status.in_acc;
            C_EXP_ZERO: hit = status.exp_zero;
            C_MOD_ZERO: hit = status.mod_zero;
            C_RED_MORE: hit = status.red_more;
            C_BIT_CLR:  hit = status.bit_clr;
            C_BIT_MORE: hit = status.bit_more;
            C_OUT_BUSY: hit = status.out_busy;
            default:    hit = 1'b1;
        endcase
        pc_next = hit ? word.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        status.in_acc |-> pc_reg == PC_IDLE)
        else $error("request accepted outside the idle step");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_DONE && status.out_busy) |=> pc_reg == PC_DONE)
        else $error("done step left while the result register is still occupied");

    a_red_loop: assert property (@(posedge clk) disable iff (!rst_n)
        ((pc_reg == PC_SQ_RED || pc_reg == PC_ML_RED) && status.red_more) |=> $stable(pc_reg))
        else $error("reduction loop left before its last step");
`endif

endmodule
`default_nettype wire

### sv/mexp_dp.sv
// Datapath: modulus register, multiplier, two-bit-per-step remainder unit and result register.
// Depends on mexp_pkg and the channel interfaces in mexp_ifs.sv.
`default_nettype none
module mexp_dp
    import mexp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire act_t   act,
    output status_t     status,
    mexp_req_if.sink    req,
    mexp_rsp_if.source  rsp,
    mexp_cfg_if.sink    cfg
);

    logic [MOD_WIDTH-1:0]    mod_reg;
    logic [BASE_WIDTH-1:0]   base_reg;
    logic [EXP_WIDTH-1:0]    exp_reg;
    logic [EXP_IDX_W-1:0]    idx_reg;
    logic [MOD_WIDTH-1:0]    t_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [RCNT_W-1:0]       rcnt_reg;
    logic [MOD_WIDTH-1:0]    rem_reg;
    logic [RESULT_WIDTH-1:0] result_reg;
    logic                    out_valid_reg;

    logic                    in_acc;
    logic                    out_free;
    logic [BASE_WIDTH-1:0]   mul_b;
    logic [MUL_W-1:0]        mul_res;
    logic [MOD_WIDTH:0]      r1_raw;
    logic [MOD_WIDTH-1:0]    r1;
    logic [MOD_WIDTH:0]      r2_raw;
    logic [MOD_WIDTH-1:0]    r2;

    assign req.ready  = act.in_ready;
    assign cfg.ready  = 1'b1;
    assign rsp.valid  = out_valid_reg;
    assign rsp.result = result_reg;

    assign in_acc   = req.valid && act.in_ready;
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        status.in_acc   = in_acc;
        status.exp_zero = (exp_reg == '0);
        status.mod_zero = (mod_reg == '0);
        status.red_more = (rcnt_reg != '0);
        status.bit_clr  = !exp_reg[EXP_WIDTH-1];
        status.bit_more = (idx_reg != '0);
        status.out_busy = !out_free;
    end

    always_comb
    begin
        mul_b   = (act.mul_op == MUL_BASE) ? base_reg : BASE_WIDTH'(t_reg);
        mul_res = MUL_W'(t_reg) * MUL_W'(mul_b);
    end

    // Restoring reduction: each step brings in two product bits, most significant first.
    always_comb
    begin
        r1_raw = {rem_reg, prod_reg[PROD_W-1]};
        r1     = (r1_raw >= {1'b0, mod_reg}) ? MOD_WIDTH'(r1_raw - {1'b0, mod_reg})
                                             : r1_raw[MOD_WIDTH-1:0];
        r2_raw = {r1, prod_reg[PROD_W-2]};
        r2     = (r2_raw >= {1'b0, mod_reg}) ? MOD_WIDTH'(r2_raw - {1'b0, mod_reg})
                                             : r2_raw[MOD_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg       <= MOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                mod_reg <= cfg.modulus;
            end
            if (act.out_load && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            base_reg <= req.base;
            exp_reg  <= req.exponent;
            idx_reg  <= EXP_IDX_W'(EXP_WIDTH - 1);
            t_reg    <= MOD_WIDTH'(1);
        end
        else
        begin
            if (act.exp_step)
            begin
                exp_reg <= exp_reg << 1;
                idx_reg <= idx_reg - EXP_IDX_W'(1);
            end
            unique case (act.t_op)
                T_REM:   t_reg <= rem_reg;
                T_ZERO:  t_reg <= '0;
                default: t_reg <= t_reg;
            endcase
        end

        if (act.mul_op != MUL_NONE)
        begin
            prod_reg <= PROD_W'(mul_res);
            rem_reg  <= '0;
            rcnt_reg <= RCNT_W'(RED_STEPS - 1);
        end
        else if (act.red_step)
        begin
            prod_reg <= prod_reg << 2;
            rem_reg  <= r2;
            rcnt_reg <= rcnt_reg - RCNT_W'(1);
        end

        if (act.out_load && out_free)
        begin
            result_reg <= t_reg;
        end
    end

`ifndef SYNTHESIS
    a_red_count_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (act.mul_op != MUL_NONE) |=> rcnt_reg == RCNT_W'(RED_STEPS - 1))
        else $error("reduction count not reloaded after a multiply");

    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        (act.out_load && out_free) |=> (rsp.valid && rsp.result == $past(t_reg)))
        else $error("finished result not posted to the response register");

    a_no_req_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (act.mul_op != MUL_NONE || act.red_step) |-> !req.ready)
        else $error("request channel open while a reduction is running");
`endif

endmodule
`default_nettype wire

### sv/modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit: sequencer plus datapath.
// Depends on mexp_pkg, mexp_ifs.sv, mexp_seq and mexp_dp.
//
// Computes base ** exponent mod modulus by left-to-right square and multiply.
// A request on req carries base (32 bits) and exponent (63 bits); each request
// gives exactly one result on rsp. The modulus is written on cfg, which is always
// ready; it resets to 1000000007 and should only change while the unit is idle.
// An exponent of zero returns 1; a modulus of zero returns 0 for nonzero exponents.
//
// One request is processed at a time. Each exponent bit costs a square and, when
// the bit is set, a multiply; each of these is a multiplier step, the reduction of
// the whole product in the two-bit-per-cycle remainder unit and a write-back step,
// and each bit ends with a step of bit bookkeeping. The remainder unit sets the run
// time. The next request can be taken in the cycle after the result is loaded.
// The result sits in an output register: a new request is accepted while it waits.
// If rsp stalls, the next computation finishes and then waits until the register
// frees. Reset returns the sequencer to idle and clears the pending result.
`default_nettype none
module modular_exponentiation_unit
    import mexp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    mexp_req_if.sink    req,
    mexp_rsp_if.source  rsp,
    mexp_cfg_if.sink    cfg
);

    act_t    act;
    status_t status;

    mexp_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .act    (act)
    );

    mexp_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .act    (act),
        .status (status),
        .req    (req),
        .rsp    (rsp),
        .cfg    (cfg)
    );

endmodule
`default_nettype wire
